/* hdl/bmcd_pkg.sv */
// ----------------------------------------------------------------------------
// bmcd_pkg
// Shared widths, reset values and register indexes of the button decoder.
// ----------------------------------------------------------------------------
package bmcd_pkg;

  // Time stamp width carried on the input stream
  localparam int unsigned NowWidth       = 32;
  localparam int unsigned TimeWidthDflt  = 32;

  // Configuration register widths
  localparam int unsigned MsWidth        = 16;
  localparam int unsigned CountWidth     = 8;
  localparam int unsigned CfgIndexWidth  = 4;
  localparam int unsigned CfgDataWidth   = 16;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InFieldBits    = 1 + NowWidth;
  localparam int unsigned InDataWidth    = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutFieldBits   = 1 + CountWidth + 1 + CountWidth;
  localparam int unsigned OutDataWidth   = ((OutFieldBits + 7) / 8) * 8;

  // Register reset values
  localparam logic [MsWidth-1:0]    HoldoffRst    = 16'd50;
  localparam logic [MsWidth-1:0]    LongPressRst  = 16'd1000;
  localparam logic [MsWidth-1:0]    ClickWinRst   = 16'd400;
  localparam logic [CountWidth-1:0] MaxClicksRst  = 8'd6;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_HOLDOFF    = 4'd0,
    REG_LONG_PRESS = 4'd1,
    REG_CLICK_WIN  = 4'd2,
    REG_MAX_CLICKS = 4'd3
  } bmcd_reg_e;

  // One result item
  typedef struct packed {
    logic [CountWidth-1:0] clicks_so_far;
    logic                  long_press_seen;
    logic [CountWidth-1:0] mode_number;
    logic                  mode_valid;
  } bmcd_result_t;

endpackage

/* hdl/button_multi_click_decoder_unit.sv */
// ----------------------------------------------------------------------------
// button_multi_click_decoder_unit
// Path: a sample accepted into the input register is decoded there and moves
//   into the result register, which drives the output until the result side
//   takes it.
// Throughput: one sample per cycle unless the result side stalls; the input
//   and result registers each advance when the next stage is free or drained.
// The whole decision is one pass of subtract/compare logic on the sample
//   held in the input register against the stored press and click state.
// Reset (rst_ni low, asynchronous): decoder state cleared, config registers
//   take their default values, both stream registers empty.
// ----------------------------------------------------------------------------
module button_multi_click_decoder_unit
  import bmcd_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDflt
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // Sample stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] button_level, [32:1] now_ms, [39:33] zero
  input  logic [InDataWidth-1:0]   s_axis_tdata,

  // Result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] mode_valid, [8:1] mode_number, [9] long_press_seen,
  // [17:10] clicks_so_far, [23:18] zero
  output logic [OutDataWidth-1:0]  m_axis_tdata,

  // Configuration write request
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, written one request per cycle.
  // --------------------------------------------------------------------------
  logic [MsWidth-1:0]    holdoff_q, long_press_q, click_win_q;
  logic [CountWidth-1:0] max_clicks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q    <= HoldoffRst;
      long_press_q <= LongPressRst;
      click_win_q  <= ClickWinRst;
      max_clicks_q <= MaxClicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HOLDOFF:    holdoff_q    <= cfg_data_i;
        REG_LONG_PRESS: long_press_q <= cfg_data_i;
        REG_CLICK_WIN:  click_win_q  <= cfg_data_i;
        REG_MAX_CLICKS: max_clicks_q <= cfg_data_i[CountWidth-1:0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the result register drains on m_axis_tready, the input
  // register refills in the same cycle it hands its sample on.
  // --------------------------------------------------------------------------
  logic                 in_valid_q;
  logic                 level_q;
  logic [NowWidth-1:0]  now_q;
  logic                 out_valid_q;
  bmcd_result_t         result_q, result_d;
  logic                 advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Sample payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      level_q <= s_axis_tdata[0];
      now_q   <= s_axis_tdata[NowWidth:1];
    end
  end

  // --------------------------------------------------------------------------
  // Decoder state
  // --------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] last_edge_q,  last_edge_d;
  logic [TIME_WIDTH-1:0] press_start_q, press_start_d;
  logic [TIME_WIDTH-1:0] last_click_q, last_click_d;
  logic                  prev_level_q, prev_level_d;
  logic                  press_active_q, press_active_d;
  logic [CountWidth-1:0] click_count_q, click_count_d;
  logic                  emit_pending_q, emit_pending_d;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] since_edge, since_press, since_click;
  logic                  holdoff_ok, rising, falling;

  // Wrap the time stamp into the time base
  assign now_t       = TIME_WIDTH'(now_q);
  assign since_edge  = now_t - last_edge_q;
  assign since_press = now_t - press_start_q;
  assign since_click = now_t - last_click_q;

  assign holdoff_ok = since_edge >= TIME_WIDTH'(holdoff_q);
  assign rising     = level_q && !prev_level_q;
  assign falling    = !level_q && prev_level_q;

  always_comb begin
    last_edge_d    = last_edge_q;
    press_start_d  = press_start_q;
    last_click_d   = last_click_q;
    prev_level_d   = prev_level_q;
    press_active_d = press_active_q;
    click_count_d  = click_count_q;
    emit_pending_d = emit_pending_q;
    result_d       = '0;

    // Samples inside the hold-off leave everything untouched
    if (holdoff_ok) begin
      prev_level_d = level_q;
      priority if (rising) begin
        press_active_d = 1'b1;
        press_start_d  = now_t;
        last_edge_d    = now_t;
      end else if (falling) begin
        // A release restarts the hold-off even without a tracked press
        last_edge_d = now_t;
        if (press_active_q) begin
          press_active_d = 1'b0;
          if (since_press >= TIME_WIDTH'(long_press_q)) begin
            result_d.long_press_seen = 1'b1;
          end else begin
            // Join the run inside the window, else start a new one
            if (since_click < TIME_WIDTH'(click_win_q)) begin
              click_count_d = click_count_q + CountWidth'(1);
            end else begin
              click_count_d = CountWidth'(1);
            end
            last_click_d   = now_t;
            emit_pending_d = 1'b1;
          end
        end
      end else if (since_click > TIME_WIDTH'(click_win_q)) begin
        // Window closed: hand out the mode once, if the count fits
        if (emit_pending_q) begin
          emit_pending_d = 1'b0;
          if (click_count_q <= max_clicks_q) begin
            result_d.mode_valid  = 1'b1;
            result_d.mode_number = click_count_q - CountWidth'(1);
          end
        end
      end
    end

    result_d.clicks_so_far = click_count_d;
  end

  // Advance state only when the sample moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q    <= '0;
      press_start_q  <= '0;
      last_click_q   <= '0;
      prev_level_q   <= 1'b0;
      press_active_q <= 1'b0;
      click_count_q  <= '0;
      emit_pending_q <= 1'b0;
    end else if (advance) begin
      last_edge_q    <= last_edge_d;
      press_start_q  <= press_start_d;
      last_click_q   <= last_click_d;
      prev_level_q   <= prev_level_d;
      press_active_q <= press_active_d;
      click_count_q  <= click_count_d;
      emit_pending_q <= emit_pending_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataWidth'(result_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_mode_or_long : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(result_q.mode_valid && result_q.long_press_seen))
    else $error("mode and long press reported together");

  a_long_ends_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result_d.long_press_seen) |=> !press_active_q)
    else $error("press still active after long press release");

  a_emit_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result_d.mode_valid) |=> !emit_pending_q)
    else $error("pending run not cleared after emitting a mode");

  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("sample accepted while both stages are stalled");

endmodule
